// File: hdl/fdr_pkg.sv
// fdr_pkg: widths, constants and sideband types for the Fresnel reflectance pipeline.
// No dependencies; used by fdr_sqrt, fdr_div and fresnel_dielectric_reflectance.
package fdr_pkg;

    localparam int D_W    = 60;   // radicand width
    localparam int Q_W    = 30;   // root width
    localparam int NUM_W  = 62;   // dividend width
    localparam int DEN_W  = 46;   // divisor width
    localparam int QB     = 17;   // quotient bits, result <= 1.0 in Q1.16

    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [14:0] ONE_Q12 = 15'd4096;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic        special;
        logic [14:0] a;
        logic [44:0] b2c;
        logic [29:0] ac;
    } t_sq_side;

    typedef struct packed {
        logic special;
    } t_dv_side;

endpackage

// File: hdl/fdr_sqrt.sv
// fdr_sqrt: pipelined restoring integer square root, one root bit per stage.
// Depends on fdr_pkg.
module fdr_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [fdr_pkg::D_W-1:0]       i_radicand,
    input  fdr_pkg::t_sq_side             i_side,
    output logic                          o_valid,
    output logic [fdr_pkg::Q_W-1:0]       o_root,
    output fdr_pkg::t_sq_side             o_side
);

    logic [fdr_pkg::Q_W:0]   r_vld;
    logic [fdr_pkg::D_W-1:0] r_rem  [0:fdr_pkg::Q_W];
    logic [fdr_pkg::Q_W-1:0] r_root [0:fdr_pkg::Q_W];
    fdr_pkg::t_sq_side       r_side [0:fdr_pkg::Q_W];

    assign r_vld[0]  = i_valid;
    assign r_rem[0]  = i_radicand;
    assign r_root[0] = '0;
    assign r_side[0] = i_side;

    for (genvar g = 0; g < fdr_pkg::Q_W; g++) begin : g_stage
        localparam int B = fdr_pkg::Q_W - 1 - g;
        logic [fdr_pkg::D_W:0] trial;
        // trial = root * 2^(B+1) + 2^(2B); root holds only bits above B
        assign trial = ({{(fdr_pkg::D_W - fdr_pkg::Q_W + 1){1'b0}}, r_root[g]} << (B + 1))
                     | ({{fdr_pkg::D_W{1'b0}}, 1'b1} << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_side[g+1] <= r_side[g];
            if ({1'b0, r_rem[g]} >= trial) begin
                r_rem[g+1]  <= r_rem[g] - trial[fdr_pkg::D_W-1:0];
                r_root[g+1] <= r_root[g] | (fdr_pkg::Q_W'(1) << B);
            end else begin
                r_rem[g+1]  <= r_rem[g];
                r_root[g+1] <= r_root[g];
            end
        end
    end

    assign o_valid = r_vld[fdr_pkg::Q_W];
    assign o_root  = r_root[fdr_pkg::Q_W];
    assign o_side  = r_side[fdr_pkg::Q_W];

endmodule

// File: hdl/fdr_div.sv
// fdr_div: pipelined restoring divider, one quotient bit per stage.
// Depends on fdr_pkg; quotient must fit in QB bits.
module fdr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [fdr_pkg::NUM_W-1:0]     i_num,
    input  logic [fdr_pkg::DEN_W-1:0]     i_den,
    input  fdr_pkg::t_dv_side             i_side,
    output logic                          o_valid,
    output logic [fdr_pkg::QB-1:0]        o_quot,
    output fdr_pkg::t_dv_side             o_side
);

    logic [fdr_pkg::QB:0]      r_vld;
    logic [fdr_pkg::NUM_W-1:0] r_rem  [0:fdr_pkg::QB];
    logic [fdr_pkg::DEN_W-1:0] r_den  [0:fdr_pkg::QB];
    logic [fdr_pkg::QB-1:0]    r_quot [0:fdr_pkg::QB];
    fdr_pkg::t_dv_side         r_side [0:fdr_pkg::QB];

    assign r_vld[0]  = i_valid;
    assign r_rem[0]  = i_num;
    assign r_den[0]  = i_den;
    assign r_quot[0] = '0;
    assign r_side[0] = i_side;

    for (genvar g = 0; g < fdr_pkg::QB; g++) begin : g_stage
        localparam int K = fdr_pkg::QB - 1 - g;
        logic [fdr_pkg::NUM_W:0] sh;
        assign sh = {{(fdr_pkg::NUM_W + 1 - fdr_pkg::DEN_W){1'b0}}, r_den[g]} << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_side[g+1] <= r_side[g];
            r_den[g+1]  <= r_den[g];
            if ({1'b0, r_rem[g]} >= sh) begin
                r_rem[g+1]  <= r_rem[g] - sh[fdr_pkg::NUM_W-1:0];
                r_quot[g+1] <= r_quot[g] | (fdr_pkg::QB'(1) << K);
            end else begin
                r_rem[g+1]  <= r_rem[g];
                r_quot[g+1] <= r_quot[g];
            end
        end
    end

    assign o_valid = r_vld[fdr_pkg::QB];
    assign o_quot  = r_quot[fdr_pkg::QB];
    assign o_side  = r_side[fdr_pkg::QB];

endmodule

// File: hdl/fresnel_dielectric_reflectance.sv
// Unpolarised dielectric Fresnel reflectance, fully pipelined.
// Throughput one item per cycle, busy is never raised.
// The depth is set by the 30-stage square root and the 17-stage dividers.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
module fresnel_dielectric_reflectance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_cos_incident,
    input  logic [15:0] i_refr_index,
    output logic        o_valid,
    output logic [16:0] o_reflectance
);

    // stage 1: decode
    logic        neg;
    logic [16:0] cmag;
    logic        r1_vld, r1_special;
    logic [14:0] r1_a, r1_b, r1_c;

    assign busy = 1'b0;
    assign neg  = i_cos_incident[15];
    assign cmag = neg ? (17'd0 - {1'b1, i_cos_incident}) : {1'b0, i_cos_incident};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
        r1_special <= i_refr_index[15] || (i_refr_index == 16'd0) || (i_cos_incident == 16'd0);
        r1_c <= (cmag > {2'b0, fdr_pkg::ONE_Q14}) ? fdr_pkg::ONE_Q14 : cmag[14:0];
        r1_a <= neg ? i_refr_index[14:0] : fdr_pkg::ONE_Q12;
        r1_b <= neg ? fdr_pkg::ONE_Q12 : i_refr_index[14:0];
    end

    // stage 2: squares
    logic        r2_vld, r2_special;
    logic [14:0] r2_a, r2_c;
    logic [29:0] r2_a2, r2_b2, r2_ac;
    logic [28:0] r2_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_special <= r1_special;
        r2_a  <= r1_a;
        r2_c  <= r1_c;
        r2_a2 <= 30'(r1_a * r1_a);
        r2_b2 <= 30'(r1_b * r1_b);
        r2_c2 <= 29'(r1_c * r1_c);
        r2_ac <= 30'(r1_a * r1_c);
    end

    // stage 3: full and lost terms
    logic        r3_vld, r3_special;
    logic [14:0] r3_a;
    logic [29:0] r3_ac;
    logic [44:0] r3_b2c;
    logic [58:0] r3_lost;
    logic [59:0] r3_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_special <= r2_special;
        r3_a    <= r2_a;
        r3_ac   <= r2_ac;
        r3_b2c  <= 45'(r2_b2 * r2_c);
        r3_lost <= 59'(r2_a2 * (29'h1000_0000 - r2_c2));
        r3_full <= {2'b0, r2_b2, 28'd0};
    end

    // stage 4: radicand, clamped at zero for total internal reflection
    logic              r4_vld;
    logic [59:0]       r4_d;
    fdr_pkg::t_sq_side r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_d <= (r3_full > {1'b0, r3_lost}) ? (r3_full - {1'b0, r3_lost}) : 60'd0;
        r4_side.special <= r3_special;
        r4_side.a       <= r3_a;
        r4_side.b2c     <= r3_b2c;
        r4_side.ac      <= r3_ac;
    end

    logic              sq_vld;
    logic [29:0]       sq_root;
    fdr_pkg::t_sq_side sq_side;

    fdr_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r4_vld),
        .i_radicand (r4_d),
        .i_side     (r4_side),
        .o_valid    (sq_vld),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    // stage 5: a * q
    logic              r5_vld;
    logic [29:0]       r5_q;
    logic [44:0]       r5_aq;
    fdr_pkg::t_sq_side r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= sq_vld;
        end
        r5_q    <= sq_root;
        r5_aq   <= 45'(sq_side.a * sq_root);
        r5_side <= sq_side;
    end

    // stage 6: magnitudes, divisors, rounded dividends
    logic [44:0] s_mag, s_den0;
    logic [45:0] s_den;
    logic [29:0] p_mag;
    logic [30:0] p_den;
    logic        r6_vld;
    logic [61:0] r6_snum, r6_pnum;
    logic [45:0] r6_sden, r6_pden;
    fdr_pkg::t_dv_side r6_side;

    assign s_mag  = (r5_side.b2c >= r5_aq) ? (r5_side.b2c - r5_aq) : (r5_aq - r5_side.b2c);
    assign s_den0 = '0;
    assign s_den  = {1'b0, r5_side.b2c} + {1'b0, r5_aq} + {1'b0, s_den0};
    assign p_mag  = (r5_side.ac >= r5_q) ? (r5_side.ac - r5_q) : (r5_q - r5_side.ac);
    assign p_den  = {1'b0, r5_side.ac} + {1'b0, r5_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_side.special <= r5_side.special;
        r6_sden <= s_den;
        r6_pden <= {15'd0, p_den};
        r6_snum <= {1'b0, s_mag, 16'd0} + {17'd0, s_den[45:1]};
        r6_pnum <= {16'd0, p_mag, 16'd0} + {32'd0, p_den[30:1]};
    end

    logic              dv_s_vld, dv_p_vld;
    logic [16:0]       dv_rs, dv_rp;
    fdr_pkg::t_dv_side dv_s_side, dv_p_side;

    fdr_div u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_num   (r6_snum),
        .i_den   (r6_sden),
        .i_side  (r6_side),
        .o_valid (dv_s_vld),
        .o_quot  (dv_rs),
        .o_side  (dv_s_side)
    );

    fdr_div u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_vld),
        .i_num   (r6_pnum),
        .i_den   (r6_pden),
        .i_side  (r6_side),
        .o_valid (dv_p_vld),
        .o_quot  (dv_rp),
        .o_side  (dv_p_side)
    );

    // stage 7: squared amplitudes
    logic        r7_vld, r7_special;
    logic [33:0] r7_ss, r7_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= dv_s_vld;
        end
        r7_special <= dv_s_side.special;
        r7_ss <= 34'(dv_rs * dv_rs);
        r7_pp <= 34'(dv_rp * dv_rp);
    end

    // stage 8: mean, rounded half up, clamped to 1.0
    logic [34:0] sum;
    logic [17:0] mean;

    assign sum  = {1'b0, r7_ss} + {1'b0, r7_pp} + 35'd65536;
    assign mean = sum[34:17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r7_vld;
        end
        if (r7_special || (mean > {1'b0, fdr_pkg::ONE_Q16})) begin
            o_reflectance <= fdr_pkg::ONE_Q16;
        end else begin
            o_reflectance <= mean[16:0];
        end
    end

`ifndef NO_ASSERTIONS
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reflectance <= fdr_pkg::ONE_Q16))
        else $error("reflectance above 1.0");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv_s_vld == dv_p_vld) && (!dv_s_vld || (dv_s_side == dv_p_side)))
        else $error("dividers out of step");

    a_special: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r7_vld && r7_special) |=> (o_valid && (o_reflectance == fdr_pkg::ONE_Q16)))
        else $error("special case not forced to full reflection");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld |-> ##30 sq_vld)
        else $error("square root latency slip");
`endif

endmodule
